FILE: rtl/core/assert_macros.svh
// assert_macros.svh: assertion shorthands for the stream decoder.
// Uses clk_i and rst_ni of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define HSD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("hsd assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define HSD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsd assertion failed");

`endif

FILE: rtl/core/hsd_pkg.sv
// hsd_pkg: shared constants and types of the stream decoder.
// No dependencies.
package hsd_pkg;

  // Tree storage and input queue sizing
  localparam int unsigned NODE_SLOTS_DEF = 512;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Count field value 0 stands for this
  localparam logic [8:0] FULL_COUNT = 9'd256;

  // Parse phases
  localparam logic [3:0] PH_COUNT   = 4'd0;
  localparam logic [3:0] PH_SYM     = 4'd1;
  localparam logic [3:0] PH_LEN     = 4'd2;
  localparam logic [3:0] PH_CODE    = 4'd3;
  localparam logic [3:0] PH_SIZE    = 4'd4;
  localparam logic [3:0] PH_NAMELEN = 4'd5;
  localparam logic [3:0] PH_NAME    = 4'd6;
  localparam logic [3:0] PH_CONTENT = 4'd7;
  localparam logic [3:0] PH_IDLE    = 4'd8;

  // Result kinds
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // One queued input beat
  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } hsd_beat_t;

endpackage

FILE: rtl/core/hsd_if.sv
// hsd_if: valid/ready channel interfaces for input bytes and decoded results.
// No dependencies.
interface hsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface hsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [1:0] kind;
  logic       last;
  modport source (output valid, output symbol, output kind, output last, input ready);
  modport sink (input valid, input symbol, input kind, input last, output ready);
endinterface

FILE: rtl/core/hsd_front.sv
// hsd_front: input side, a short beat queue that decouples the byte source
// from the bit-serial back end. Depends on hsd_pkg.
module hsd_front import hsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hsd_beat_t in_beat_i,
  output logic      beat_valid_o,
  output hsd_beat_t beat_o,
  input  logic      beat_pop_i
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  hsd_beat_t         queue_q [QUEUE_DEPTH];
  logic [PW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o   = (cnt_q != CW'(QUEUE_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign pop          = beat_pop_i && beat_valid_o;
  assign beat_valid_o = (cnt_q != '0);
  assign beat_o       = queue_q[rptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Beat storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= in_beat_i;
    end
  end

endmodule

FILE: rtl/core/hsd_back.sv
// hsd_back: bit-serial parser, tree builder and tree walker with node memory
// and the result register. Depends on hsd_pkg.
module hsd_back import hsd_pkg::*; #(
  parameter int unsigned NODE_SLOTS = NODE_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_valid_i,
  input  hsd_beat_t  beat_i,
  output logic       beat_pop_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] symbol_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  localparam int unsigned IW = $clog2(NODE_SLOTS);
  localparam int unsigned NW = IW + 1;

  localparam logic [2:0] ST_FETCH = 3'd0;
  localparam logic [2:0] ST_BIT   = 3'd1;
  localparam logic [2:0] ST_CRD   = 3'd2;
  localparam logic [2:0] ST_CLINK = 3'd3;
  localparam logic [2:0] ST_CADV  = 3'd4;
  localparam logic [2:0] ST_DRD   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  // Node memory, split by field so each array has one write port
  logic [IW-1:0] zero_mem [NODE_SLOTS];
  logic [IW-1:0] one_mem  [NODE_SLOTS];
  logic [7:0]    sym_mem  [NODE_SLOTS];
  logic [IW-1:0] rd_zero_q, rd_one_q;
  logic [7:0]    rd_sym_q;

  logic [2:0]    state_q, state_d;
  logic [7:0]    shreg_q, shreg_d;
  logic [2:0]    bitcnt_q, bitcnt_d;
  logic [3:0]    phase_q, phase_d;
  logic [7:0]    gather_q, gather_d;
  logic [2:0]    gcnt_q, gcnt_d;
  logic [8:0]    entries_q, entries_d;
  logic [7:0]    esym_q, esym_d;
  logic [8:0]    cleft_q, cleft_d;
  logic [IW-1:0] walk_q, walk_d;
  logic [2:0]    sidx_q, sidx_d;
  logic [63:0]   content_q, content_d;
  logic [7:0]    name_q, name_d;
  logic [NW-1:0] nf_q, nf_d;
  logic [IW-1:0] root_zero_q, root_zero_d, root_one_q, root_one_d;
  logic [IW-1:0] cur_zero_q, cur_zero_d, cur_one_q, cur_one_d;
  logic [IW-1:0] link_q, link_d;
  logic [7:0]    res_sym_q, res_sym_d;
  logic [1:0]    res_kind_q, res_kind_d;
  logic          res_last_q, res_last_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_sym_q, out_sym_d;
  logic [1:0]    out_kind_q, out_kind_d;
  logic          out_last_q, out_last_d;

  logic          bit_v;
  logic [7:0]    fval;
  logic [IW-1:0] raddr, nxt, link_c, cz, co;
  logic          zw_en, ow_en, sw_en;
  logic [IW-1:0] zw_addr, zw_data, ow_addr, ow_data, sw_addr;
  logic [3:0]    leaf_phase;

  assign bit_v       = shreg_q[7];
  assign fval        = {gather_q[6:0], bit_v};
  assign res_valid_o = out_valid_q;
  assign symbol_o    = out_sym_q;
  assign kind_o      = out_kind_q;
  assign last_o      = out_last_q;

  always_comb begin
    state_d = state_q;   shreg_d = shreg_q;     bitcnt_d = bitcnt_q;
    phase_d = phase_q;   gather_d = gather_q;   gcnt_d = gcnt_q;
    entries_d = entries_q; esym_d = esym_q;     cleft_d = cleft_q;
    walk_d = walk_q;     sidx_d = sidx_q;       content_d = content_q;
    name_d = name_q;     nf_d = nf_q;
    root_zero_d = root_zero_q; root_one_d = root_one_q;
    cur_zero_d = cur_zero_q;   cur_one_d = cur_one_q;
    link_d = link_q;
    res_sym_d = res_sym_q; res_kind_d = res_kind_q; res_last_d = res_last_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_sym_d = out_sym_q; out_kind_d = out_kind_q; out_last_d = out_last_q;
    beat_pop_o = 1'b0;
    raddr = walk_q;
    zw_en = 1'b0; zw_addr = walk_q; zw_data = '0;
    ow_en = 1'b0; ow_addr = walk_q; ow_data = '0;
    sw_en = 1'b0; sw_addr = link_q;
    leaf_phase = phase_q;
    cz = (walk_q == '0) ? root_zero_q : rd_zero_q;
    co = (walk_q == '0) ? root_one_q : rd_one_q;
    link_c = bit_v ? co : cz;
    nxt = bit_v ? ((walk_q == '0) ? root_one_q : cur_one_q)
                : ((walk_q == '0) ? root_zero_q : cur_zero_q);

    case (state_q)
      // Take the next byte; a restart beat clears the stream state first
      ST_FETCH: begin
        if (beat_valid_i) begin
          beat_pop_o = 1'b1;
          shreg_d    = beat_i.data_byte;
          bitcnt_d   = '0;
          state_d    = ST_BIT;
          if (beat_i.restart) begin
            phase_d = PH_COUNT;  gather_d = '0;  gcnt_d = '0;
            entries_d = '0;      esym_d = '0;    cleft_d = '0;
            walk_d = '0;         sidx_d = '0;    content_d = '0;
            name_d = '0;         nf_d = NW'(1);
            root_zero_d = '0;    root_one_d = '0;
          end
        end
      end

      // Dispatch one bit by parse phase
      ST_BIT: begin
        case (phase_q)
          PH_IDLE: state_d = ST_FETCH;
          PH_CODE: begin
            raddr   = walk_q;
            state_d = ST_CRD;
          end
          PH_NAME, PH_CONTENT: begin
            if (nxt == '0) begin
              res_sym_d = '0; res_kind_d = KIND_ERROR; res_last_d = 1'b1;
              phase_d = PH_IDLE;
              state_d = ST_EMIT;
            end else begin
              raddr   = nxt;
              link_d  = nxt;
              state_d = ST_DRD;
            end
          end
          default: begin
            // Header field gathering
            if (gcnt_q == 3'd7) begin
              gcnt_d   = '0;
              gather_d = '0;
              case (phase_q)
                PH_COUNT: begin
                  entries_d = (fval == '0) ? FULL_COUNT : {1'b0, fval};
                  phase_d   = PH_SYM;
                end
                PH_SYM: begin
                  esym_d  = fval;
                  phase_d = PH_LEN;
                end
                PH_LEN: begin
                  cleft_d = (fval == '0) ? FULL_COUNT : {1'b0, fval};
                  walk_d  = '0;
                  phase_d = PH_CODE;
                end
                PH_SIZE: begin
                  if (sidx_q == '0) begin
                    content_d = '0;
                  end
                  content_d[{sidx_q, 3'b000} +: 8] = fval;
                  sidx_d = sidx_q + 1'b1;
                  if (sidx_q == 3'd7) begin
                    phase_d = PH_NAMELEN;
                  end
                end
                default: begin
                  name_d = fval;
                  walk_d = '0;
                  if (fval != '0) begin
                    phase_d = PH_NAME;
                  end else if (content_q != '0) begin
                    phase_d = PH_CONTENT;
                  end else begin
                    phase_d = PH_IDLE;
                  end
                end
              endcase
            end else begin
              gather_d = fval;
              gcnt_d   = gcnt_q + 1'b1;
            end
            shreg_d  = {shreg_q[6:0], 1'b0};
            bitcnt_d = bitcnt_q + 1'b1;
            state_d  = (bitcnt_q == 3'd7) ? ST_FETCH : ST_BIT;
          end
        endcase
      end

      // Code bit: follow the link, allocate a cleared node, or flag an error when no node is free
      ST_CRD: begin
        if (link_c != '0) begin
          link_d  = link_c;
          state_d = ST_CADV;
        end else if (nf_q >= NW'(NODE_SLOTS)) begin
          res_sym_d = '0; res_kind_d = KIND_ERROR; res_last_d = 1'b1;
          phase_d = PH_IDLE;
          state_d = ST_EMIT;
        end else begin
          zw_en = 1'b1; zw_addr = nf_q[IW-1:0]; zw_data = '0;
          ow_en = 1'b1; ow_addr = nf_q[IW-1:0]; ow_data = '0;
          link_d  = nf_q[IW-1:0];
          state_d = ST_CLINK;
        end
      end

      // Hook the new node under the current one
      ST_CLINK: begin
        if (walk_q == '0) begin
          if (bit_v) begin
            root_one_d = link_q;
          end else begin
            root_zero_d = link_q;
          end
        end else if (bit_v) begin
          ow_en = 1'b1; ow_addr = walk_q; ow_data = link_q;
        end else begin
          zw_en = 1'b1; zw_addr = walk_q; zw_data = link_q;
        end
        nf_d    = nf_q + 1'b1;
        state_d = ST_CADV;
      end

      // Step down; at the end of the code store the symbol
      ST_CADV: begin
        cleft_d = cleft_q - 1'b1;
        if (cleft_q == 9'd1) begin
          sw_en     = 1'b1;
          sw_addr   = link_q;
          walk_d    = '0;
          entries_d = entries_q - 1'b1;
          phase_d   = (entries_q == 9'd1) ? PH_SIZE : PH_SYM;
          sidx_d    = '0;
        end else begin
          walk_d = link_q;
        end
        shreg_d  = {shreg_q[6:0], 1'b0};
        bitcnt_d = bitcnt_q + 1'b1;
        state_d  = (bitcnt_q == 3'd7) ? ST_FETCH : ST_BIT;
      end

      // Decode bit: inner node continues, childless node yields a symbol
      ST_DRD: begin
        if (rd_zero_q != '0 || rd_one_q != '0) begin
          walk_d     = link_q;
          cur_zero_d = rd_zero_q;
          cur_one_d  = rd_one_q;
          shreg_d    = {shreg_q[6:0], 1'b0};
          bitcnt_d   = bitcnt_q + 1'b1;
          state_d    = (bitcnt_q == 3'd7) ? ST_FETCH : ST_BIT;
        end else begin
          walk_d = '0;
          if (phase_q == PH_NAME) begin
            name_d = name_q - 1'b1;
            if (name_q == 8'd1) begin
              leaf_phase = (content_q != '0) ? PH_CONTENT : PH_IDLE;
            end
            res_kind_d = KIND_NAME;
          end else begin
            content_d = content_q - 1'b1;
            if (content_q == 64'd1) begin
              leaf_phase = PH_IDLE;
            end
            res_kind_d = KIND_CONTENT;
          end
          phase_d    = leaf_phase;
          res_sym_d  = rd_sym_q;
          res_last_d = (leaf_phase == PH_IDLE);
          state_d    = ST_EMIT;
        end
      end

      // Hand the result to the output register once it has room
      ST_EMIT: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          out_sym_d   = res_sym_q;
          out_kind_d  = res_kind_q;
          out_last_d  = res_last_q;
          shreg_d     = {shreg_q[6:0], 1'b0};
          bitcnt_d    = bitcnt_q + 1'b1;
          state_d     = (bitcnt_q == 3'd7) ? ST_FETCH : ST_BIT;
        end
      end

      default: state_d = ST_FETCH;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FETCH;  bitcnt_q <= '0;  phase_q <= PH_COUNT;
      gather_q <= '0;       gcnt_q <= '0;    entries_q <= '0;
      esym_q <= '0;         cleft_q <= '0;   walk_q <= '0;
      sidx_q <= '0;         content_q <= '0; name_q <= '0;
      nf_q <= NW'(1);       root_zero_q <= '0; root_one_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;   bitcnt_q <= bitcnt_d; phase_q <= phase_d;
      gather_q <= gather_d; gcnt_q <= gcnt_d;     entries_q <= entries_d;
      esym_q <= esym_d;     cleft_q <= cleft_d;   walk_q <= walk_d;
      sidx_q <= sidx_d;     content_q <= content_d; name_q <= name_d;
      nf_q <= nf_d;         root_zero_q <= root_zero_d; root_one_q <= root_one_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    cur_zero_q <= cur_zero_d; cur_one_q <= cur_one_d;
    link_q <= link_d;
    res_sym_q <= res_sym_d; res_kind_q <= res_kind_d; res_last_q <= res_last_d;
    out_sym_q <= out_sym_d; out_kind_q <= out_kind_d; out_last_q <= out_last_d;
  end

  // Node memory ports, read data registered
  always_ff @(posedge clk_i) begin
    if (zw_en) begin
      zero_mem[zw_addr] <= zw_data;
    end
    if (ow_en) begin
      one_mem[ow_addr] <= ow_data;
    end
    if (sw_en) begin
      sym_mem[sw_addr] <= esym_q;
    end
    rd_zero_q <= zero_mem[raddr];
    rd_one_q  <= one_mem[raddr];
    rd_sym_q  <= sym_mem[raddr];
  end

endmodule

FILE: rtl/core/huffman_stream_decoder_top.sv
// Usage notes for the stream decoder with in-band code table.
// Channels: in_i carries one compressed byte per beat (data_byte, restart);
// out_o carries one decoded result per beat (symbol, kind, last). Both are
// valid/ready; a beat moves when valid and ready are high at a clock edge.
// A beat with restart set clears the tree and begins a new stream.
// Processing: the back end handles each header bit in its bit state; each
// code-table bit runs a node read, an optional allocate and link write and a
// step, and each decoded bit a node read and a decide step; loading a byte
// and emitting a result have states of their own. The node memory port sets
// the pace of content bytes.
// A two-beat input queue lets bytes arrive while the back end works.
// Reset: the stream waits for a symbol count; no result is pending.
// Receiver stall: one finished result waits in the output register; the
// back end stops at its next result until that one is taken, and the input
// queue then fills and drops ready.
// Depends on hsd_pkg, hsd_if, hsd_front, hsd_back, assert_macros.svh.
`include "assert_macros.svh"
module huffman_stream_decoder_top import hsd_pkg::*; #(
  parameter int unsigned NODE_SLOTS = NODE_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsd_in_if.sink     in_i,
  hsd_out_if.source  out_o
);

  hsd_beat_t in_beat, q_beat;
  logic      q_valid, q_pop;

  assign in_beat.data_byte = in_i.data_byte;
  assign in_beat.restart   = in_i.restart;

  // Input queue
  hsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_beat_i    (in_beat),
    .beat_valid_o (q_valid),
    .beat_o       (q_beat),
    .beat_pop_i   (q_pop)
  );

  // Parser and tree engine
  hsd_back #(.NODE_SLOTS(NODE_SLOTS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (q_valid),
    .beat_i       (q_beat),
    .beat_pop_o   (q_pop),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .symbol_o     (out_o.symbol),
    .kind_o       (out_o.kind),
    .last_o       (out_o.last)
  );

  `HSD_ASSERT_IMPLY(a_pop_needs_beat, q_pop, q_valid)
  `HSD_ASSERT_IMPLY(a_error_ends_stream, out_o.valid && out_o.kind == KIND_ERROR, out_o.last && out_o.symbol == 8'd0)
  `HSD_ASSERT_ALWAYS(a_full_queue_offers, in_i.ready || q_valid)

endmodule
